### src/esi_pkg.sv
// Shared constants, width helpers and control types for the edge span interpolator.
package esi_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_ROWS      = 64;
  localparam int HEIGHT_W      = 7;
  localparam int ROW_W         = 6;
  // The row count of an edge (end - start + 1) reaches 65536.
  localparam int ROWS_W        = 17;
  // Number of rows skipped above the screen, at most 32768.
  localparam int K_W           = 16;

  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(64);

  // Magnitude width of the largest dividend: the column delta times 2^frac
  // or a texture delta plus its sign.
  function automatic int mag_width(input int frac);
    return (frac + 17 > 33) ? frac + 17 : 33;
  endfunction

  // Width of the shared adder and of every signed accumulator.
  function automatic int acc_width(input int frac);
    return mag_width(frac) + 2;
  endfunction

  typedef enum logic {
    OP_DIV,
    OP_MUL
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  typedef struct packed {
    logic             load;
    logic             side;
    logic [ROW_W-1:0] first_row;
    logic [ROW_W-1:0] last_row;
  } walk_ctl_t;

endpackage

### src/esi_if.sv
// Channel interfaces for the edge span interpolator: edge words, row words, configuration.
interface esi_in_if;
  logic               valid;
  logic               ready;
  logic               side;
  logic signed [15:0] start_row;
  logic signed [15:0] start_col;
  logic signed [15:0] end_row;
  logic signed [15:0] end_col;
  logic signed [31:0] tex_start_u;
  logic signed [31:0] tex_start_v;
  logic signed [31:0] tex_end_u;
  logic signed [31:0] tex_end_v;

  modport source (
    output valid, side, start_row, start_col, end_row, end_col,
    output tex_start_u, tex_start_v, tex_end_u, tex_end_v,
    input  ready
  );
  modport sink (
    input  valid, side, start_row, start_col, end_row, end_col,
    input  tex_start_u, tex_start_v, tex_end_u, tex_end_v,
    output ready
  );
endinterface

interface esi_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         row;
  logic               side_out;
  logic signed [15:0] span_col;
  logic signed [31:0] tex_u;
  logic signed [31:0] tex_v;
  logic               last;

  modport source (
    output valid, row, side_out, span_col, tex_u, tex_v, last,
    input  ready
  );
  modport sink (
    input  valid, row, side_out, span_col, tex_u, tex_v, last,
    output ready
  );
endinterface

interface esi_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] screen_height;

  modport source (output valid, screen_height, input ready);
  modport sink   (input valid, screen_height, output ready);
endinterface

### src/edge_span_interpolator_unit.sv
// Top level of the edge span interpolator: sequencer, edge word latch and height register.
//
// Use: one word on in_ch describes one sprite edge (side, two screen endpoints with the
// first on the smaller row, and the texture coordinates at both ends). The block answers
// with one word per visible screen row on out_ch, from the top row down, and raises last
// on the final word of the edge. Flat, reversed or fully off-screen edges produce no word.
// cfg_ch writes screen_height, the visible row count used for clipping; it is always ready
// and is meant to be written only while no edge is in flight.
// Flow: an accepted edge passes through the check state, then three signed divisions in
// the shared divider, whose quotient is DW = max(FRAC_BITS+17, 33) bits wide. If the edge
// starts above row 0, three multiply-adds in the same unit advance it to row 0. After the
// load state the row walker delivers one word per cycle while out_ch is ready. in_ch.ready
// is low from acceptance until the last row word has been taken; a stall on out_ch simply
// holds the word.
// Reset (rst_n low at a clock edge) returns to idle, drops any pending words and sets
// screen_height to 64. No clearing pass is needed.
module edge_span_interpolator_unit #(
  parameter int FRAC_BITS = esi_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  esi_in_if.sink    in_ch,
  esi_out_if.source out_ch,
  esi_cfg_if.sink   cfg_ch
);

  localparam int PW    = esi_pkg::acc_width(FRAC_BITS);
  localparam int HW    = esi_pkg::HEIGHT_W;
  localparam int ROW_W = esi_pkg::ROW_W;
  localparam int RW    = esi_pkg::ROWS_W;
  localparam int KW    = esi_pkg::K_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIVX,
    S_DIVU,
    S_DIVV,
    S_MULX,
    S_MULU,
    S_MULV,
    S_GO
  } state_t;

  state_t              state_r;
  esi_pkg::arith_req_t req_r;
  logic [HW-1:0]       height_r;

  // Latched edge word.
  logic        side_r;
  logic [15:0] r1_r;
  logic [15:0] c1_r;
  logic [15:0] r2_r;
  logic [15:0] c2_r;
  logic [31:0] u1_r;
  logic [31:0] v1_r;
  logic [31:0] u2_r;
  logic [31:0] v2_r;

  // Per-row increments and the values at the first visible row.
  logic signed [PW-1:0] xinc_r;
  logic signed [PW-1:0] uinc_r;
  logic signed [PW-1:0] vinc_r;
  logic signed [PW-1:0] x0_r;
  logic signed [PW-1:0] u0_r;
  logic signed [PW-1:0] v0_r;

  logic                 arith_done;
  logic signed [PW-1:0] arith_res;
  logic signed [PW-1:0] opnd_a;
  logic [RW-1:0]        opnd_b;
  logic signed [PW-1:0] opnd_c;

  logic                 walk_busy;
  esi_pkg::walk_ctl_t   walk_ctl;

  logic [HW-1:0]        h_eff;
  logic signed [15:0]   h_s;
  logic [16:0]          r1_x;
  logic [16:0]          r2_x;
  logic [RW-1:0]        rows;
  logic [KW-1:0]        skip_rows;
  logic                 skip;
  logic                 clip_end;
  logic                 starts_above;
  logic [17:0]          dc;
  logic [32:0]          du_d;
  logic [32:0]          dv_d;
  logic [33:0]          du;
  logic [33:0]          dv;
  logic [PW-1:0]        xnum;
  logic [PW-1:0]        du_x;
  logic [PW-1:0]        dv_x;
  logic [PW-1:0]        base_x;
  logic [PW-1:0]        base_u;
  logic [PW-1:0]        base_v;

  // Heights above the row limit behave as the limit.
  assign h_eff = (height_r > HW'(esi_pkg::MAX_ROWS)) ? HW'(esi_pkg::MAX_ROWS) : height_r;
  assign h_s   = $signed(16'(h_eff));

  assign r1_x      = {r1_r[15], r1_r};
  assign r2_x      = {r2_r[15], r2_r};
  assign rows      = r2_x - r1_x + 17'd1;
  assign skip_rows = KW'(17'd0 - r1_x);

  assign starts_above = r1_r[15];
  assign clip_end     = ($signed(r2_r) >= h_s);
  // Flat, reversed, below-the-screen, above-the-screen edges and a zero height give no rows.
  assign skip = ($signed(r1_r) >= $signed(r2_r)) || ($signed(r1_r) >= h_s) ||
                r2_r[15] || (h_eff == '0);

  // Column delta plus one, scaled to fixed point.
  assign dc   = {c2_r[15], c2_r[15], c2_r} - {c1_r[15], c1_r[15], c1_r} + 18'd1;
  assign xnum = {{(PW-18){dc[17]}}, dc} << FRAC_BITS;

  // Texture deltas are widened by one step in the direction of their sign.
  assign du_d = {u2_r[31], u2_r} - {u1_r[31], u1_r};
  assign dv_d = {v2_r[31], v2_r} - {v1_r[31], v1_r};
  assign du   = {du_d[32], du_d} + (du_d[32] ? 34'h3_FFFF_FFFF : {33'd0, |du_d});
  assign dv   = {dv_d[32], dv_d} + (dv_d[32] ? 34'h3_FFFF_FFFF : {33'd0, |dv_d});
  assign du_x = {{(PW-34){du[33]}}, du};
  assign dv_x = {{(PW-34){dv[33]}}, dv};

  assign base_x = {{(PW-16){c1_r[15]}}, c1_r} << FRAC_BITS;
  assign base_u = {{(PW-32){u1_r[31]}}, u1_r};
  assign base_v = {{(PW-32){v1_r[31]}}, v1_r};

  // Operands for the shared unit follow the sequencer state; the unit samples
  // them in the cycle its start request is high.
  always_comb begin
    opnd_a = $signed(xnum);
    opnd_b = rows;
    opnd_c = $signed(base_x);
    case (state_r)
      S_DIVX: begin
        opnd_a = $signed(xnum);
      end
      S_DIVU: begin
        opnd_a = $signed(du_x);
      end
      S_DIVV: begin
        opnd_a = $signed(dv_x);
      end
      S_MULX: begin
        opnd_a = xinc_r;
        opnd_b = {1'b0, skip_rows};
        opnd_c = $signed(base_x);
      end
      S_MULU: begin
        opnd_a = uinc_r;
        opnd_b = {1'b0, skip_rows};
        opnd_c = $signed(base_u);
      end
      S_MULV: begin
        opnd_a = vinc_r;
        opnd_b = {1'b0, skip_rows};
        opnd_c = $signed(base_v);
      end
      default: begin
        opnd_b = rows;
      end
    endcase
  end

  // The walk starts at row 0 when the edge begins above the screen and ends
  // at the bottom visible row when it reaches past it.
  always_comb begin
    walk_ctl.load      = (state_r == S_GO);
    walk_ctl.side      = side_r;
    walk_ctl.first_row = starts_above ? '0 : r1_r[ROW_W-1:0];
    walk_ctl.last_row  = clip_end ? ROW_W'(h_eff - HW'(1)) : r2_r[ROW_W-1:0];
  end

  assign in_ch.ready  = (state_r == S_IDLE) && !walk_busy;
  assign cfg_ch.ready = 1'b1;

  // The start request is a one-cycle pulse: every arm either raises it for
  // the next operation or drops it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      req_r    <= '{start: 1'b0, op: esi_pkg::OP_DIV};
      height_r <= esi_pkg::HEIGHT_RST;
    end else begin
      if (cfg_ch.valid) begin
        height_r <= cfg_ch.screen_height;
      end
      case (state_r)
        S_IDLE: begin
          req_r.start <= 1'b0;
          if (in_ch.valid && !walk_busy) begin
            side_r  <= in_ch.side;
            r1_r    <= in_ch.start_row;
            c1_r    <= in_ch.start_col;
            r2_r    <= in_ch.end_row;
            c2_r    <= in_ch.end_col;
            u1_r    <= in_ch.tex_start_u;
            v1_r    <= in_ch.tex_start_v;
            u2_r    <= in_ch.tex_end_u;
            v2_r    <= in_ch.tex_end_v;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (skip) begin
            req_r.start <= 1'b0;
            state_r     <= S_IDLE;
          end else begin
            req_r   <= '{start: 1'b1, op: esi_pkg::OP_DIV};
            state_r <= S_DIVX;
          end
        end
        S_DIVX: begin
          if (arith_done) begin
            xinc_r  <= arith_res;
            req_r   <= '{start: 1'b1, op: esi_pkg::OP_DIV};
            state_r <= S_DIVU;
          end else begin
            req_r.start <= 1'b0;
          end
        end
        S_DIVU: begin
          if (arith_done) begin
            uinc_r  <= arith_res;
            req_r   <= '{start: 1'b1, op: esi_pkg::OP_DIV};
            state_r <= S_DIVV;
          end else begin
            req_r.start <= 1'b0;
          end
        end
        S_DIVV: begin
          if (arith_done) begin
            vinc_r <= arith_res;
            if (starts_above) begin
              req_r   <= '{start: 1'b1, op: esi_pkg::OP_MUL};
              state_r <= S_MULX;
            end else begin
              req_r.start <= 1'b0;
              x0_r        <= $signed(base_x);
              u0_r        <= $signed(base_u);
              v0_r        <= $signed(base_v);
              state_r     <= S_GO;
            end
          end else begin
            req_r.start <= 1'b0;
          end
        end
        S_MULX: begin
          if (arith_done) begin
            x0_r    <= arith_res;
            req_r   <= '{start: 1'b1, op: esi_pkg::OP_MUL};
            state_r <= S_MULU;
          end else begin
            req_r.start <= 1'b0;
          end
        end
        S_MULU: begin
          if (arith_done) begin
            u0_r    <= arith_res;
            req_r   <= '{start: 1'b1, op: esi_pkg::OP_MUL};
            state_r <= S_MULV;
          end else begin
            req_r.start <= 1'b0;
          end
        end
        S_MULV: begin
          req_r.start <= 1'b0;
          if (arith_done) begin
            v0_r    <= arith_res;
            state_r <= S_GO;
          end
        end
        S_GO: begin
          req_r.start <= 1'b0;
          state_r     <= S_IDLE;
        end
        default: begin
          req_r.start <= 1'b0;
          state_r     <= S_IDLE;
        end
      endcase
    end
  end

  esi_arith #(
    .FRAC_BITS (FRAC_BITS)
  ) u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req_r),
    .opnd_a (opnd_a),
    .opnd_b (opnd_b),
    .opnd_c (opnd_c),
    .done   (arith_done),
    .result (arith_res)
  );

  esi_walker #(
    .FRAC_BITS (FRAC_BITS)
  ) u_walker (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (walk_ctl),
    .x0     (x0_r),
    .u0     (u0_r),
    .v0     (v0_r),
    .xinc   (xinc_r),
    .uinc   (uinc_r),
    .vinc   (vinc_r),
    .busy   (walk_busy),
    .out_ch (out_ch)
  );

endmodule

### src/esi_arith.sv
// Shared iterative unit: signed division by a row count and signed shift-add multiply-add.
module esi_arith #(
  parameter int FRAC_BITS = esi_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  esi_pkg::arith_req_t               req,
  input  logic signed [esi_pkg::acc_width(FRAC_BITS)-1:0] opnd_a,
  input  logic [esi_pkg::ROWS_W-1:0]        opnd_b,
  input  logic signed [esi_pkg::acc_width(FRAC_BITS)-1:0] opnd_c,
  output logic                              done,
  output logic signed [esi_pkg::acc_width(FRAC_BITS)-1:0] result
);

  localparam int DW    = esi_pkg::mag_width(FRAC_BITS);
  localparam int PW    = esi_pkg::acc_width(FRAC_BITS);
  localparam int RW    = esi_pkg::ROWS_W;
  localparam int KW    = esi_pkg::K_W;
  localparam int CNT_W = $clog2(DW + 1);

  typedef enum logic [2:0] {
    U_IDLE,
    U_ABS,
    U_DIV,
    U_NEG,
    U_MUL,
    U_ADD
  } ustate_t;

  ustate_t          state_r;
  logic [CNT_W-1:0] cnt_r;
  logic             neg_r;
  logic [RW-1:0]    rem_r;
  logic [DW-1:0]    quo_r;
  logic [PW-1:0]    acc_r;
  logic [PW-1:0]    mcand_r;
  logic [PW-1:0]    base_r;
  logic [RW-1:0]    kdiv_r;
  logic             done_r;
  logic [PW-1:0]    result_r;

  logic [RW:0]      rem_sh;
  logic [PW-1:0]    opa;
  logic [PW-1:0]    opb;
  logic             cin;
  logic [PW-1:0]    sum;
  logic             ge;

  assign rem_sh = {rem_r, quo_r[DW-1]};

  // The one adder of the unit; every step routes its operands through here.
  always_comb begin
    opa = acc_r;
    opb = '0;
    cin = 1'b0;
    case (state_r)
      U_ABS: begin
        opa = neg_r ? ~acc_r : acc_r;
        cin = neg_r;
      end
      U_DIV: begin
        opa = PW'(rem_sh);
        opb = ~PW'(kdiv_r);
        cin = 1'b1;
      end
      U_NEG: begin
        opa = neg_r ? ~PW'(quo_r) : PW'(quo_r);
        cin = neg_r;
      end
      U_MUL: begin
        opa = {acc_r[PW-2:0], 1'b0};
        opb = kdiv_r[KW-1] ? mcand_r : '0;
      end
      U_ADD: begin
        opa = acc_r;
        opb = base_r;
      end
      default: begin
        opa = acc_r;
      end
    endcase
  end

  assign sum = opa + opb + PW'(cin);
  assign ge  = ~sum[PW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      done_r  <= 1'b0;
    end else begin
      case (state_r)
        U_IDLE: begin
          done_r <= 1'b0;
          if (req.start) begin
            mcand_r <= opnd_a;
            base_r  <= opnd_c;
            kdiv_r  <= opnd_b;
            neg_r   <= opnd_a[PW-1];
            if (req.op == esi_pkg::OP_DIV) begin
              acc_r   <= opnd_a;
              state_r <= U_ABS;
            end else begin
              acc_r   <= '0;
              cnt_r   <= CNT_W'(KW - 1);
              state_r <= U_MUL;
            end
          end
        end
        U_ABS: begin
          done_r  <= 1'b0;
          quo_r   <= sum[DW-1:0];
          rem_r   <= '0;
          cnt_r   <= CNT_W'(DW - 1);
          state_r <= U_DIV;
        end
        U_DIV: begin
          done_r <= 1'b0;
          quo_r  <= {quo_r[DW-2:0], ge};
          rem_r  <= ge ? sum[RW-1:0] : rem_sh[RW-1:0];
          if (cnt_r == '0) begin
            state_r <= U_NEG;
          end else begin
            cnt_r <= cnt_r - CNT_W'(1);
          end
        end
        U_NEG: begin
          result_r <= sum;
          done_r   <= 1'b1;
          state_r  <= U_IDLE;
        end
        U_MUL: begin
          done_r <= 1'b0;
          acc_r  <= sum;
          kdiv_r <= {kdiv_r[RW-2:0], 1'b0};
          if (cnt_r == '0) begin
            state_r <= U_ADD;
          end else begin
            cnt_r <= cnt_r - CNT_W'(1);
          end
        end
        U_ADD: begin
          result_r <= sum;
          done_r   <= 1'b1;
          state_r  <= U_IDLE;
        end
        default: begin
          done_r  <= 1'b0;
          state_r <= U_IDLE;
        end
      endcase
    end
  end

  assign done   = done_r;
  assign result = $signed(result_r);

endmodule

### src/esi_walker.sv
// Row walker: steps the screen x and texture accumulators one row per delivered word.
module esi_walker #(
  parameter int FRAC_BITS = esi_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  esi_pkg::walk_ctl_t  ctl,
  input  logic signed [esi_pkg::acc_width(FRAC_BITS)-1:0] x0,
  input  logic signed [esi_pkg::acc_width(FRAC_BITS)-1:0] u0,
  input  logic signed [esi_pkg::acc_width(FRAC_BITS)-1:0] v0,
  input  logic signed [esi_pkg::acc_width(FRAC_BITS)-1:0] xinc,
  input  logic signed [esi_pkg::acc_width(FRAC_BITS)-1:0] uinc,
  input  logic signed [esi_pkg::acc_width(FRAC_BITS)-1:0] vinc,
  output logic                busy,
  esi_out_if.source           out_ch
);

  localparam int PW    = esi_pkg::acc_width(FRAC_BITS);
  localparam int CW    = PW - FRAC_BITS;
  localparam int ROW_W = esi_pkg::ROW_W;

  logic             valid_r;
  logic [ROW_W-1:0] row_r;
  logic [ROW_W-1:0] last_row_r;
  logic             side_r;
  logic [PW-1:0]    x_r;
  logic [PW-1:0]    u_r;
  logic [PW-1:0]    v_r;

  logic [CW-1:0]    col_full;
  logic [CW-16:0]   col_hi;
  logic [15:0]      col_sat;
  logic             is_last;

  // Dropping the fraction bits of a two's complement value floors it.
  assign col_full = x_r[PW-1:FRAC_BITS];
  assign col_hi   = col_full[CW-1:15];

  always_comb begin
    if ((col_hi == '0) || (col_hi == '1)) begin
      col_sat = col_full[15:0];
    end else if (col_full[CW-1]) begin
      col_sat = 16'h8000;
    end else begin
      col_sat = 16'h7FFF;
    end
  end

  assign is_last = (row_r == last_row_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      if (ctl.load) begin
        valid_r    <= 1'b1;
        row_r      <= ctl.first_row;
        last_row_r <= ctl.last_row;
        side_r     <= ctl.side;
        x_r        <= x0;
        u_r        <= u0;
        v_r        <= v0;
      end else if (valid_r && out_ch.ready) begin
        if (is_last) begin
          valid_r <= 1'b0;
        end else begin
          row_r <= row_r + ROW_W'(1);
          x_r   <= x_r + xinc;
          u_r   <= u_r + uinc;
          v_r   <= v_r + vinc;
        end
      end
    end
  end

  assign busy            = valid_r;
  assign out_ch.valid    = valid_r;
  assign out_ch.row      = row_r;
  assign out_ch.side_out = side_r;
  assign out_ch.span_col = $signed(col_sat);
  assign out_ch.tex_u    = $signed(u_r[31:0]);
  assign out_ch.tex_v    = $signed(v_r[31:0]);
  assign out_ch.last     = is_last;

endmodule

### tb/sv/tb_edge_span_interpolator_unit.sv
// Self-checking testbench for the edge span interpolator: directed edges, then random edges.
module tb_edge_span_interpolator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PERIOD = 10;
  localparam int FRAC = esi_pkg::FRAC_BITS_DEF;
  // An edge that makes no word is dropped right after its check cycle, and
  // one that makes words is owed until its last word, so this quiet time is
  // ample before any height write and before the final verdict.
  localparam int DRAIN = 400;
  // The slowest correct edge runs three divisions and three multiply-adds, then 64 words,
  // each of which can wait out a long random stall on the receiver.
  localparam int LIMIT = 3_000_000;
  localparam int SEG_EDGES = 50;
  localparam int NUM_SEGS = 6;
  localparam int HOLD_CYCLES = 600;

  // One edge word as it travels on the input channel.
  typedef struct packed {
    logic        side;
    logic [15:0] start_row;
    logic [15:0] start_col;
    logic [15:0] end_row;
    logic [15:0] end_col;
    logic [31:0] tex_start_u;
    logic [31:0] tex_start_v;
    logic [31:0] tex_end_u;
    logic [31:0] tex_end_v;
  } edge_word_t;

  // One row word as it travels on the result channel.
  typedef struct packed {
    logic [esi_pkg::ROW_W-1:0] row;
    logic                      side_out;
    logic [15:0]               span_col;
    logic [31:0]               tex_u;
    logic [31:0]               tex_v;
    logic                      last;
  } row_word_t;

  // A line of the directed table. A negative typed_n means the rows come from
  // the predictor; otherwise w0 and w1 hold the first typed_n words by hand.
  typedef struct packed {
    edge_word_t e;
    int         typed_n;
    row_word_t  w0;
    row_word_t  w1;
  } plan_line_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  esi_in_if  in_ch();
  esi_out_if out_ch();
  esi_cfg_if cfg_ch();

  edge_span_interpolator_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #(PERIOD/2) clk = ~clk;

  // Words still owed by the block, oldest first.
  row_word_t  pending_rows[$];
  plan_line_t plan[$];

  // The edge currently offered on the input channel, with its typed rows.
  edge_word_t cur_edge;
  int         cur_typed_n;
  row_word_t  cur_w0, cur_w1;

  // Our copy of the height register, updated when a write is taken.
  logic [esi_pkg::HEIGHT_W-1:0] height_now = esi_pkg::HEIGHT_RST;

  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int hold_left = 0;
  int errors = 0;
  int edges_taken = 0;
  int words_checked = 0;
  int heights_written = 0;
  int cycles = 0;

  // Walks one edge row by row the way the block should: fixed-point steps,
  // truncating divisions, advance to row 0 when the edge starts above the
  // screen, and clipping at the bottom. Returns the number of words; when
  // record is set the words are also queued as expectations.
  function automatic int walk_edge(edge_word_t e, logic [esi_pkg::HEIGHT_W-1:0] height,
                                   bit record);
    longint one, h, r1, r2, c1, c2, u1, v1, u2, v2;
    longint rows, xinc, uinc, vinc, du, dv, x, u, v, y, col;
    int n;
    row_word_t w;
    one = longint'(1) << FRAC;
    h = (height > esi_pkg::MAX_ROWS) ? longint'(esi_pkg::MAX_ROWS) : longint'(height);
    r1 = longint'($signed(e.start_row));
    c1 = longint'($signed(e.start_col));
    r2 = longint'($signed(e.end_row));
    c2 = longint'($signed(e.end_col));
    u1 = longint'($signed(e.tex_start_u));
    v1 = longint'($signed(e.tex_start_v));
    u2 = longint'($signed(e.tex_end_u));
    v2 = longint'($signed(e.tex_end_v));
    n = 0;
    // Flat, reversed and off-screen edges, and a zero height, make no word.
    if (r1 >= r2 || r1 >= h || r2 < 0) begin
      return 0;
    end
    rows = r2 - r1 + 1;
    xinc = ((c2 - c1 + 1) * one) / rows;
    // The texture deltas are widened by one in the direction of travel.
    du = u2 - u1;
    if (du > 0) du++;
    else if (du < 0) du--;
    dv = v2 - v1;
    if (dv > 0) dv++;
    else if (dv < 0) dv--;
    uinc = du / rows;
    vinc = dv / rows;
    x = c1 * one;
    u = u1;
    v = v1;
    if (r1 < 0) begin
      x += xinc * -r1;
      u += uinc * -r1;
      v += vinc * -r1;
      r1 = 0;
    end
    if (r2 >= h) r2 = h - 1;
    for (y = r1; y <= r2 && n < esi_pkg::MAX_ROWS; y++) begin
      // An arithmetic shift floors toward minus infinity.
      col = x >>> FRAC;
      if (col > 32767) col = 32767;
      if (col < -32768) col = -32768;
      w.row = esi_pkg::ROW_W'(y);
      w.side_out = e.side;
      w.span_col = col[15:0];
      w.tex_u = u[31:0];
      w.tex_v = v[31:0];
      w.last = (y == r2);
      if (record) pending_rows.push_back(w);
      n++;
      x += xinc;
      u += uinc;
      v += vinc;
    end
    return n;
  endfunction

  function automatic edge_word_t mk_edge(logic side, int r1, int c1, int r2, int c2,
                                         logic [31:0] u1, logic [31:0] v1,
                                         logic [31:0] u2, logic [31:0] v2);
    edge_word_t e;
    e.side = side;
    e.start_row = r1[15:0];
    e.start_col = c1[15:0];
    e.end_row = r2[15:0];
    e.end_col = c2[15:0];
    e.tex_start_u = u1;
    e.tex_start_v = v1;
    e.tex_end_u = u2;
    e.tex_end_v = v2;
    return e;
  endfunction

  function automatic row_word_t mk_row(int row, logic side, int col, logic [31:0] u,
                                      logic [31:0] v, logic last);
    row_word_t w;
    w.row = row[esi_pkg::ROW_W-1:0];
    w.side_out = side;
    w.span_col = col[15:0];
    w.tex_u = u;
    w.tex_v = v;
    w.last = last;
    return w;
  endfunction

  // Random edges. Most are well formed and land near the screen so that the
  // walk, the advance to row 0 and the clipping all get exercised; some span
  // the whole row range, and the rest are noise, which is mostly flat,
  // reversed or off screen.
  function automatic edge_word_t random_edge();
    edge_word_t e;
    int kind, r1, r2, a, b;
    kind = int'($urandom_range(0, 99));
    e.side = 1'($urandom_range(0, 1));
    e.start_col = 16'($urandom);
    e.end_col = 16'($urandom);
    e.tex_start_u = 32'($urandom);
    e.tex_start_v = 32'($urandom);
    e.tex_end_u = 32'($urandom);
    e.tex_end_v = 32'($urandom);
    if (kind < 70) begin
      r1 = int'($urandom_range(0, 150)) - 80;
      r2 = r1 + int'($urandom_range(1, 100));
      e.start_row = r1[15:0];
      e.end_row = r2[15:0];
      // Half of these keep columns and texture near each other.
      if ($urandom_range(0, 1) == 1) begin
        e.start_col = 16'(int'($urandom_range(0, 900)) - 300);
        e.end_col = 16'(int'($urandom_range(0, 900)) - 300);
        e.tex_end_u = e.tex_start_u + 32'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
        e.tex_end_v = e.tex_start_v + 32'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      end
    end else if (kind < 85) begin
      a = int'($signed(16'($urandom)));
      b = int'($signed(16'($urandom)));
      e.start_row = (a < b) ? a[15:0] : b[15:0];
      e.end_row = (a < b) ? b[15:0] : a[15:0];
    end else begin
      e.start_row = 16'($urandom);
      e.end_row = ($urandom_range(0, 3) == 0) ? e.start_row : 16'($urandom);
    end
    return e;
  endfunction

  // Offers one edge, with random idle cycles ahead of it, and returns at the
  // falling edge after it has been taken. Called at a falling edge.
  task automatic send_edge(edge_word_t e, int typed_n, row_word_t w0, row_word_t w1);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cur_edge = e;
    cur_typed_n = typed_n;
    cur_w0 = w0;
    cur_w1 = w1;
    in_ch.valid <= 1'b1;
    in_ch.side <= e.side;
    in_ch.start_row <= e.start_row;
    in_ch.start_col <= e.start_col;
    in_ch.end_row <= e.end_row;
    in_ch.end_col <= e.end_col;
    in_ch.tex_start_u <= e.tex_start_u;
    in_ch.tex_start_v <= e.tex_start_v;
    in_ch.tex_end_u <= e.tex_end_u;
    in_ch.tex_end_v <= e.tex_end_v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // The height may only change while no edge is in flight: wait for every
  // owed word, give a silent edge time to finish, then write.
  task automatic write_height(logic [esi_pkg::HEIGHT_W-1:0] h);
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.screen_height <= h;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    heights_written++;
  endtask

  function automatic void check_field(string name, longint want, longint got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Scoreboard. Everything is sampled at the rising edge; the result side is
  // handled before the input side so that a word always meets the
  // expectations of edges taken earlier.
  always @(posedge clk) begin
    row_word_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        words_checked++;
        if (pending_rows.size() == 0) begin
          $error("row word for row %0d arrived with nothing owed", out_ch.row);
          errors++;
        end else begin
          want = pending_rows.pop_front();
          check_field("row", longint'(want.row), longint'(out_ch.row));
          check_field("side_out", longint'(want.side_out), longint'(out_ch.side_out));
          check_field("span_col", longint'($signed(want.span_col)),
                      longint'($signed(out_ch.span_col)));
          check_field("tex_u", longint'($signed(want.tex_u)),
                      longint'($signed(out_ch.tex_u)));
          check_field("tex_v", longint'($signed(want.tex_v)),
                      longint'($signed(out_ch.tex_v)));
          check_field("last", longint'(want.last), longint'(out_ch.last));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        edges_taken++;
        if (cur_typed_n < 0) begin
          void'(walk_edge(cur_edge, height_now, 1'b1));
        end else begin
          if (cur_typed_n > 0) pending_rows.push_back(cur_w0);
          if (cur_typed_n > 1) pending_rows.push_back(cur_w1);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        height_now = cfg_ch.screen_height;
      end
    end
  end

  // Receiver. Stalls at random, or holds off completely while hold_left
  // counts down, which fills the block and stalls the input side too.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  // Watchdog on the total run length.
  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_edge_span_interpolator_unit: done, errors");
    $finish;
  end

  initial begin
    logic [esi_pkg::HEIGHT_W-1:0] seg_height [NUM_SEGS];
    edge_word_t e;
    int sent, seg;

    in_ch.valid = 1'b0;
    in_ch.side = 1'b0;
    in_ch.start_row = '0;
    in_ch.start_col = '0;
    in_ch.end_row = '0;
    in_ch.end_col = '0;
    in_ch.tex_start_u = '0;
    in_ch.tex_start_v = '0;
    in_ch.tex_end_u = '0;
    in_ch.tex_end_v = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.screen_height = '0;

    // Heights for the random segments: the smallest visible screen, the
    // largest encodable value (clamped to 64 rows), zero rows, and a few
    // ordinary ones.
    seg_height[0] = 7'd1;
    seg_height[1] = 7'd127;
    seg_height[2] = 7'd0;
    seg_height[3] = 7'd37;
    seg_height[4] = 7'd64;
    seg_height[5] = 7'd13;

    // Directed table, run at the reset height of 64. The typed lines are the
    // ones whose answer is plain: silent edges, and short edges with no
    // slope to speak of.
    // Flat edge, also at both row extremes.
    plan.push_back('{mk_edge(0, 5, 10, 5, 20, 0, 0, 0, 0), 0, '0, '0});
    plan.push_back('{mk_edge(1, 32767, -1, 32767, 0, '1, '1, '1, '1), 0, '0, '0});
    plan.push_back('{mk_edge(0, -32768, 0, -32768, -1, 0, 0, '1, '1), 0, '0, '0});
    // Reversed rows.
    plan.push_back('{mk_edge(1, 10, 0, 3, 0, 0, 0, 0, 0), 0, '0, '0});
    // Wholly below the reset height, and wholly above the screen.
    plan.push_back('{mk_edge(0, 64, 0, 100, 0, 0, 0, 0, 0), 0, '0, '0});
    plan.push_back('{mk_edge(1, -20, 5, -1, 5, 0, 0, 0, 0), 0, '0, '0});
    // Two rows, no slope: columns and texture stay put.
    plan.push_back('{mk_edge(1, 0, 0, 1, 0, 0, 0, 0, 0), 2,
                     mk_row(0, 1, 0, 0, 0, 0), mk_row(1, 1, 0, 0, 0, 1)});
    // Starts on the last row at reset, so exactly one word at the start point.
    plan.push_back('{mk_edge(0, 63, -5, 64, 1000, 32'h12345678, -7, 0, 100), 1,
                     mk_row(63, 0, -5, 32'h12345678, -7, 1), '0});
    // Full row range, full column range, texture from one extreme to the other.
    plan.push_back('{mk_edge(0, -32768, -32768, 32767, 32767, 32'h80000000, 32'h80000000,
                             32'h7fffffff, 32'h7fffffff), -1, '0, '0});
    plan.push_back('{mk_edge(1, -32768, 32767, 32767, -32768, 32'h7fffffff, 32'h80000000,
                             32'h80000000, 32'h7fffffff), -1, '0, '0});
    // A steep edge started far above the screen, once rising and once falling,
    // reaches row 0 with its column near the far end of its range.
    plan.push_back('{mk_edge(1, -32768, -32768, 1, 32767, 0, 0, 32'h00010000, 0),
                     -1, '0, '0});
    plan.push_back('{mk_edge(0, -32768, 32767, 1, -32768, 0, 0, 0, 32'h00010000),
                     -1, '0, '0});
    // Starts above, ends inside; one visible row only; exactly the full screen.
    plan.push_back('{mk_edge(0, -10, 100, 20, -40, 32'h00050000, 32'hfff80000,
                             32'h00100000, 32'h00020000), -1, '0, '0});
    plan.push_back('{mk_edge(1, -1, 7, 0, 9, 32'h00001000, 32'h00002000,
                             32'h00003000, 32'h00004000), -1, '0, '0});
    plan.push_back('{mk_edge(0, 0, 10, 63, -50, 100, -100, 200, -300), -1, '0, '0});
    // Very long edge clipped at the bottom, and all-ones values.
    plan.push_back('{mk_edge(1, 0, 0, 32767, 32767, 0, 0, 32'h7fffffff, 32'h80000000),
                     -1, '0, '0});
    plan.push_back('{mk_edge(1, -1, -1, 1, -1, '1, '1, '1, '1), -1, '0, '0});
    // Texture deltas of one step, and the widest opposite deltas.
    plan.push_back('{mk_edge(0, 0, 0, 1, 3, 0, 0, 1, '1), -1, '0, '0});
    plan.push_back('{mk_edge(1, 5, 3, 9, 4, 32'h7fffffff, 32'h80000000, 32'h80000000,
                             32'h7fffffff), -1, '0, '0});

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    in_idle_pct = 7;
    out_idle_pct = 56;
    foreach (plan[i]) begin
      send_edge(plan[i].e, plan[i].typed_n, plan[i].w0, plan[i].w1);
    end
    in_ch.valid <= 1'b0;

    // Random segments. The first two have a mostly stalled receiver, the
    // next two a mostly idle sender, the last two no idling at all.
    for (seg = 0; seg < NUM_SEGS; seg++) begin
      write_height(seg_height[seg]);
      if (seg < 2) begin
        in_idle_pct = 7;
        out_idle_pct = 56;
      end else if (seg < 4) begin
        in_idle_pct = 56;
        out_idle_pct = 7;
      end else begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      // Long hold-off on the receiver while edges keep coming.
      if (seg == 4) begin
        @(posedge clk);
        hold_left = HOLD_CYCLES;
        @(negedge clk);
      end
      // Every segment sends the same number of edges, whatever the height.
      sent = 0;
      while (sent < SEG_EDGES) begin
        e = random_edge();
        sent++;
        send_edge(e, -1, '0, '0);
      end
      in_ch.valid <= 1'b0;
    end

    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Covered %0d edges and %0d row words under %0d height settings,",
             edges_taken, words_checked, heights_written + 1);
    $display("with silent, clipped, saturating and back-pressured edges included.");
    if (errors == 0) begin
      $display("tb_edge_span_interpolator_unit: done, clean");
    end else begin
      $display("tb_edge_span_interpolator_unit: done, errors");
    end
    $finish;
  end

endmodule

### files.f
src/esi_pkg.sv
src/esi_if.sv
src/esi_arith.sv
src/esi_walker.sv
src/edge_span_interpolator_unit.sv
tb/sv/tb_edge_span_interpolator_unit.sv
